// ===== sv/orp_pkg.sv =====
// orp_pkg: shared types and constants for overlay_row_placement.
// No dependencies.
package orp_pkg;
   localparam int MAX_ROWS_DEF = 2048;
   localparam logic [11:0] DISP_H_RESET = 12'd720;
   localparam logic [1:0] CSR_DISP_H = 2'd0;
   localparam logic [1:0] CSR_MULTI = 2'd1;
   localparam logic [1:0] CMD_SCROLL = 2'd0;
   localparam logic [1:0] CMD_TOP = 2'd1;
   localparam logic [1:0] CMD_BOTTOM = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // datapath commands from controller
   typedef struct packed {
      logic clr;       // clearing pass write
      logic load;      // latch request word
      logic head_acc;  // accumulate first window
      logic slide;     // add entering row, drop leaving row, compare
      logic wr;        // write end time at addr
   } ctl_type;

   typedef struct packed {
      logic too_tall;
      logic zero_h;
      logic bad_cmd;
   } sts_type;
endpackage

// ===== sv/overlay_row_placement.sv =====
// overlay_row_placement: top level, overlay window placement over row stores.
// Depends on orp_pkg, orp_ctrl, orp_datapath, orp_ram.
//
//  channel | ports                                  | handshake
//  request | req_cmd .. req_end_time                | start & !busy
//  result  | rsp_row, rsp_too_tall                  | rsp_valid, one cycle
//  config  | csr_we, csr_index, csr_wdata           | csr_we
//
// After reset a clearing pass zeroes all MAX_ROWS rows of the stores; busy high.
// With r = min(display_height, MAX_ROWS) and h the height, a placed request
// first sums rows 0..h-1, then reads a leaving and an entering row for each
// further window, as both share the single store port, then writes its end
// time to h rows from the best window, then gives its word. Too tall: end time
// to rows 0..r-1, then the word; unused store or zero height: next cycle.
// busy drops the cycle after the word; the receiver cannot stall.
module overlay_row_placement #(
   parameter int MAX_ROWS = orp_pkg::MAX_ROWS_DEF,
   localparam int AW = $clog2(MAX_ROWS)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_font_size,
   input  logic [3:0]  req_extra_lines,
   input  logic [31:0] req_release_time,
   input  logic [31:0] req_end_time,
   output logic        rsp_valid,
   output logic [10:0] rsp_row,
   output logic        rsp_too_tall,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);
   logic [11:0] disp_h_ff;
   logic        multi_ff;
   orp_pkg::ctl_type ctl;
   orp_pkg::sts_type sts;
   logic [AW-1:0] addr, win_idx, best_idx;
   logic done;

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_h_ff <= orp_pkg::DISP_H_RESET; multi_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            orp_pkg::CSR_DISP_H: disp_h_ff <= csr_wdata;
            orp_pkg::CSR_MULTI:  multi_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   orp_ctrl #(.MAX_ROWS(MAX_ROWS)) u_ctrl (.clock, .reset, .start, .req_cmd,
      .req_font_size, .req_extra_lines, .disp_h(disp_h_ff), .multi(multi_ff),
      .best_idx, .busy, .ctl, .addr, .win_idx, .done, .sts);

   orp_datapath #(.MAX_ROWS(MAX_ROWS)) u_dp (.clock, .ctl, .addr, .win_idx,
      .req_cmd, .req_release_time, .req_end_time, .best_idx);

   assign rsp_valid = done;
   assign rsp_row = (sts.too_tall || sts.zero_h || sts.bad_cmd) ? 11'd0
                                                                : 11'(best_idx);
   assign rsp_too_tall = sts.too_tall;
endmodule

// ===== sv/orp_ram.sv =====
// orp_ram: generic single-port RAM with registered read.
// No dependencies.
module orp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// ===== sv/orp_datapath.sv =====
// orp_datapath: three row stores, window sums and best-window tracking.
// Depends on orp_pkg, orp_ram.
module orp_datapath #(
   parameter int MAX_ROWS = orp_pkg::MAX_ROWS_DEF,
   localparam int AW = $clog2(MAX_ROWS)
) (
   input  logic              clock,
   input  orp_pkg::ctl_type  ctl,
   input  logic [AW-1:0]     addr,
   input  logic [AW-1:0]     win_idx,
   input  logic [1:0]        req_cmd,
   input  logic [31:0]       req_release_time,
   input  logic [31:0]       req_end_time,
   output logic [AW-1:0]     best_idx
);
   logic [1:0]  cmd_ff;
   logic [31:0] rel_ff, end_ff;
   logic [31:0] rd_s, rd_t, rd_b, rdata;
   logic [63:0] sum_ff, best_ff;
   logic [AW-1:0] best_ff_i;
   logic [31:0] lead_ff, cur;
   logic [32:0] ov;
   logic [63:0] sum_in;
   logic we_s, we_t, we_b;
   logic [31:0] wdata;

   assign wdata = ctl.clr ? 32'd0 : end_ff;
   assign we_s = ctl.clr || (ctl.wr && cmd_ff == orp_pkg::CMD_SCROLL);
   assign we_t = ctl.clr || (ctl.wr && cmd_ff == orp_pkg::CMD_TOP);
   assign we_b = ctl.clr || (ctl.wr && cmd_ff == orp_pkg::CMD_BOTTOM);

   orp_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_s (.clock, .we(we_s), .addr,
      .wdata, .rdata(rd_s));
   orp_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_t (.clock, .we(we_t), .addr,
      .wdata, .rdata(rd_t));
   orp_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_b (.clock, .we(we_b), .addr,
      .wdata, .rdata(rd_b));

   always_comb begin
      case (cmd_ff)
         orp_pkg::CMD_TOP:    rdata = rd_t;
         orp_pkg::CMD_BOTTOM: rdata = rd_b;
         default:             rdata = rd_s;
      endcase
   end

   assign ov  = {1'b0, rdata} - {1'b0, rel_ff};
   assign cur = ov[32] ? 32'd0 : ov[31:0];

   // slide: rdata alternates leaving row (registered in lead_ff) then entering row
   always_comb begin
      sum_in = sum_ff;
      if (ctl.head_acc) sum_in = sum_ff + {32'd0, cur};
      else if (ctl.slide) sum_in = sum_ff + {32'd0, cur} - {32'd0, lead_ff};
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_cmd;
         rel_ff <= req_release_time;
         end_ff <= req_end_time;
         sum_ff <= '0;
         best_ff_i <= '0;
      end else begin
         sum_ff <= sum_in;
         lead_ff <= cur;
         if (ctl.slide) begin
            if ((cmd_ff == orp_pkg::CMD_BOTTOM) ? (sum_in <= best_ff)
                                                 : (sum_in < best_ff)) begin
               best_ff   <= sum_in;
               best_ff_i <= win_idx;
            end
         end else if (ctl.head_acc) begin
            best_ff <= sum_in;
         end
      end
   end
   assign best_idx = best_ff_i;
endmodule

// ===== sv/orp_ctrl.sv =====
// orp_ctrl: sequencer for clear, scan and write-back phases.
// Depends on orp_pkg.
module orp_ctrl #(
   parameter int MAX_ROWS = orp_pkg::MAX_ROWS_DEF,
   localparam int AW = $clog2(MAX_ROWS),
   localparam int CW = AW + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_cmd,
   input  logic [7:0]       req_font_size,
   input  logic [3:0]       req_extra_lines,
   input  logic [11:0]      disp_h,
   input  logic             multi,
   input  logic [AW-1:0]    best_idx,
   output logic             busy,
   output orp_pkg::ctl_type ctl,
   output logic [AW-1:0]    addr,
   output logic [AW-1:0]    win_idx,
   output logic             done,
   output orp_pkg::sts_type sts
);
   typedef enum logic [6:0] {
      ST_CLR  = 7'b0000001,
      ST_IDLE = 7'b0000010,
      ST_HEAD = 7'b0000100,
      ST_LEAD = 7'b0001000,
      ST_ENTR = 7'b0010000,
      ST_WR   = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, rows_ff, h_ff, i_ff, i_in;
   logic [CW-1:0] i_nx;
   logic [CW-1:0] rows_c;
   logic [11:0] h_full;
   logic pend_ff, pend_in;
   orp_pkg::sts_type sts_ff, sts_in;
   logic [CW-1:0] rows_in, h_in;

   assign rows_c = ({1'b0, disp_h} > 13'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(disp_h);
   assign h_full = multi ? ({4'd0, req_font_size} *
                            {7'd0, ({1'b0, req_extra_lines} + 5'd1)})
                         : {4'd0, req_font_size};
   // window to work on next: after a slide move on by one
   assign i_nx = pend_ff ? i_ff + 1'b1 : i_ff;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; i_in = i_ff;
      pend_in = 1'b0; sts_in = sts_ff; rows_in = rows_ff; h_in = h_ff;
      ctl = '0; addr = cnt_ff[AW-1:0]; win_idx = i_ff[AW-1:0]; done = 1'b0;
      unique case (state_ff)
         ST_CLR: begin
            ctl.clr = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MAX_ROWS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               rows_in = rows_c;
               sts_in = '0;
               cnt_in = '0; i_in = '0;
               if (req_cmd == orp_pkg::CMD_UNUSED) begin
                  sts_in.bad_cmd = 1'b1; state_in = ST_DONE;
               end else if ({1'b0, h_full} > {1'b0, 12'(rows_c)}) begin
                  sts_in.too_tall = 1'b1; h_in = rows_c;
                  if (rows_c == '0) state_in = ST_DONE;
                  else state_in = ST_WR;
               end else if (h_full == 12'd0) begin
                  sts_in.zero_h = 1'b1; state_in = ST_DONE;
               end else begin
                  h_in = CW'(h_full); state_in = ST_HEAD;
               end
            end
         end
         ST_HEAD: begin
            // read rows 0..h-1; the read is registered, so data arrives in the cycle after
            ctl.head_acc = pend_ff;
            if (cnt_ff < h_ff) begin
               pend_in = 1'b1; cnt_in = cnt_ff + 1'b1;
            end else if (!pend_ff) begin
               i_in = CW'(1); state_in = ST_LEAD;
            end
         end
         ST_LEAD: begin
            // with pend the entering row of window i is in: slide and compare
            ctl.slide = pend_ff;
            i_in = i_nx;
            if (i_nx + h_ff > rows_ff) begin
               state_in = ST_WR; cnt_in = '0;
            end else begin
               addr = AW'(i_nx - 1'b1);
               state_in = ST_ENTR;
            end
         end
         ST_ENTR: begin
            // leaving row is in now and lands in lead_ff; fetch entering row
            addr = AW'(i_ff + h_ff - 1'b1);
            pend_in = 1'b1;
            state_in = ST_LEAD;
         end
         ST_WR: begin
            ctl.wr = 1'b1;
            addr = AW'(CW'(best_idx) + cnt_ff);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff + 1'b1 >= h_ff) state_in = ST_DONE;
         end
         ST_DONE: begin
            done = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR; cnt_ff <= '0; pend_ff <= 1'b0; sts_ff <= '0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; pend_ff <= pend_in;
         sts_ff <= sts_in;
      end
      i_ff <= i_in; rows_ff <= rows_in; h_ff <= h_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign sts = sts_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> state_ff == ST_IDLE) else $error("done not followed by idle");
   a_clr_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.clr |-> busy) else $error("clear while idle");
   a_wr_not_bad: assert property (@(posedge clock) disable iff (reset)
      ctl.wr |-> !sts_ff.bad_cmd) else $error("write on unused store");
endmodule
